// ===== hdl/svpwm_pkg.sv =====
// Shared constants for the space vector PWM duty core.
// No dependencies; used by space_vector_pwm_duty_core.
`timescale 1ns / 1ps
`default_nettype none
package svpwm_pkg;
    localparam int          DATA_W         = 16;
    localparam int          FRAC_BITS_DEF  = 14;
    localparam logic [15:0] PERIOD_RESET   = 16'd199;
    localparam logic [2:0]  SECTOR_1       = 3'd1;
    localparam logic [2:0]  SECTOR_2       = 3'd2;
    localparam logic [2:0]  SECTOR_3       = 3'd3;
    localparam logic [2:0]  SECTOR_4       = 3'd4;
    localparam logic [2:0]  SECTOR_5       = 3'd5;
    localparam logic [2:0]  SECTOR_6       = 3'd6;
endpackage
`default_nettype wire

// ===== hdl/space_vector_pwm_duty_core.sv =====
// Space vector PWM duty core: sector, active times and compare values.
// Depends on svpwm_pkg.
`timescale 1ns / 1ps
`default_nettype none
// One transaction is taken in every cycle (busy stays low). Each result comes
// out in order, flagged by o_valid, and it must be taken then since there is
// no back-pressure. The pipeline is the restoring divider, one quotient bit
// per pipeline stage (FRAC_BITS+1 stages), plus input, load, multiply and
// output stages. carrier_period may be written at any time the pipeline is
// empty; cfg_ready is always high.
module space_vector_pwm_duty_core #(
    parameter int FRAC_BITS = svpwm_pkg::FRAC_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [15:0] i_phase_a_ref,
    input  wire logic [15:0] i_phase_b_ref,
    input  wire logic [15:0] i_phase_c_ref,
    input  wire logic [15:0] i_dc_bus,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data,
    output logic             o_valid,
    output logic [15:0]      o_duty_a,
    output logic [15:0]      o_duty_b,
    output logic [15:0]      o_duty_c,
    output logic [2:0]       o_sector,
    output logic             o_overmodulated
);
    localparam int QW = FRAC_BITS + 1;
    localparam int PW = svpwm_pkg::DATA_W + QW;
    localparam logic [PW:0] HALF = (PW+1)'(1) << (FRAC_BITS - 1);

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // configuration register
    logic [15:0] r_period;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= svpwm_pkg::PERIOD_RESET;
        end else if (i_cfg_valid) begin
            r_period <= i_cfg_data;
        end
    end

    // stage 0: input capture, zero bus treated as one
    logic               r_v0;
    logic signed [15:0] r_a, r_b, r_c;
    logic [15:0]        r_bus;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= start;
        end
        r_a   <= i_phase_a_ref;
        r_b   <= i_phase_b_ref;
        r_c   <= i_phase_c_ref;
        r_bus <= (i_dc_bus == 16'd0) ? 16'd1 : i_dc_bus;
    end

    // stage 1 logic: min/max, differences, denominator, sector
    logic signed [15:0] n_mn, n_mx;
    logic signed [16:0] n_span_s, n_da_s, n_db_s, n_dc_s;
    logic               n_over;
    logic [15:0]        n_den;
    logic [2:0]         n_sec;
    always_comb begin
        n_mn = r_a;
        if (r_b < n_mn) n_mn = r_b;
        if (r_c < n_mn) n_mn = r_c;
        n_mx = r_a;
        if (r_b > n_mx) n_mx = r_b;
        if (r_c > n_mx) n_mx = r_c;
        n_span_s = 17'(n_mx) - 17'(n_mn);
        n_da_s   = 17'(r_a) - 17'(n_mn);
        n_db_s   = 17'(r_b) - 17'(n_mn);
        n_dc_s   = 17'(r_c) - 17'(n_mn);
        n_over   = n_span_s[15:0] > r_bus;
        n_den    = n_over ? n_span_s[15:0] : r_bus;
        if (r_b > r_c && r_a >= r_b) begin
            n_sec = svpwm_pkg::SECTOR_1;
        end else if (r_b > r_a && r_a >= r_c) begin
            n_sec = svpwm_pkg::SECTOR_2;
        end else if (r_c > r_a && r_b >= r_c) begin
            n_sec = svpwm_pkg::SECTOR_3;
        end else if (r_c > r_b && r_b >= r_a) begin
            n_sec = svpwm_pkg::SECTOR_4;
        end else if (r_a > r_b && r_c >= r_a) begin
            n_sec = svpwm_pkg::SECTOR_5;
        end else begin
            n_sec = svpwm_pkg::SECTOR_6;
        end
    end

    // divider pipeline: stage k holds remainder and partial quotient
    logic          r_dv  [0:QW];
    logic [16:0]   r_rem [0:QW][0:2];
    logic [QW-1:0] r_quo [0:QW][0:2];
    logic [15:0]   r_den [0:QW];
    logic [2:0]    r_sec [0:QW];
    logic          r_ovr [0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QW; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else begin
            r_dv[0] <= r_v0;
            for (int k = 0; k < QW; k++) begin
                r_dv[k+1] <= r_dv[k];
            end
        end
        // load
        r_rem[0][0] <= {1'b0, n_da_s[15:0]};
        r_rem[0][1] <= {1'b0, n_db_s[15:0]};
        r_rem[0][2] <= {1'b0, n_dc_s[15:0]};
        for (int p = 0; p < 3; p++) begin
            r_quo[0][p] <= '0;
        end
        r_den[0] <= n_den;
        r_sec[0] <= n_sec;
        r_ovr[0] <= n_over;
        // one quotient bit per stage, stored remainder stays below twice the divisor
        for (int k = 0; k < QW; k++) begin
            for (int p = 0; p < 3; p++) begin
                if (r_rem[k][p] >= {1'b0, r_den[k]}) begin
                    r_rem[k+1][p] <= {r_rem[k][p][15:0] - r_den[k], 1'b0};
                    r_quo[k+1][p] <= {r_quo[k][p][QW-2:0], 1'b1};
                end else begin
                    r_rem[k+1][p] <= {r_rem[k][p][15:0], 1'b0};
                    r_quo[k+1][p] <= {r_quo[k][p][QW-2:0], 1'b0};
                end
            end
            r_den[k+1] <= r_den[k];
            r_sec[k+1] <= r_sec[k];
            r_ovr[k+1] <= r_ovr[k];
        end
    end

    // multiply stage: period times normalised time
    logic          r_mv;
    logic [PW-1:0] r_prod [0:2];
    logic [2:0]    r_msec;
    logic          r_movr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else begin
            r_mv <= r_dv[QW];
        end
        for (int p = 0; p < 3; p++) begin
            r_prod[p] <= PW'(r_period) * PW'(r_quo[QW][p]);
        end
        r_msec <= r_sec[QW];
        r_movr <= r_ovr[QW];
    end

    // output stage: round half up and scale back
    logic [PW:0] n_sum [0:2];
    always_comb begin
        for (int p = 0; p < 3; p++) begin
            n_sum[p] = {1'b0, r_prod[p]} + HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_mv;
        end
        o_duty_a        <= n_sum[0][FRAC_BITS +: 16];
        o_duty_b        <= n_sum[1][FRAC_BITS +: 16];
        o_duty_c        <= n_sum[2][FRAC_BITS +: 16];
        o_sector        <= r_msec;
        o_overmodulated <= r_movr;
    end
endmodule
`default_nettype wire

// ===== tb/sv/space_vector_pwm_duty_core_test.sv =====
// Self-checking testbench for space_vector_pwm_duty_core.
// Depends on svpwm_pkg and the core; a directed table runs first, then random
// transactions, checked against typed-in results or an in-bench duty and sector predictor.
`timescale 1ns / 1ps
module space_vector_pwm_duty_core_test;
    localparam int FRAC = svpwm_pkg::FRAC_BITS_DEF;
    localparam int LATENCY = FRAC + 5;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [15:0] duty_a;
        logic [15:0] duty_b;
        logic [15:0] duty_c;
        logic [2:0]  sector;
        logic        overmodulated;
    } duty_set_t;

    typedef struct {
        logic [15:0] a, b, c, bus;
        logic        known;   // expected result typed in below
        duty_set_t   res;
    } vec_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [15:0] i_phase_a_ref = '0, i_phase_b_ref = '0, i_phase_c_ref = '0;
    logic [15:0] i_dc_bus = 16'd1;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [15:0] i_cfg_data = '0;
    logic o_valid;
    logic [15:0] o_duty_a, o_duty_b, o_duty_c;
    logic [2:0] o_sector;
    logic o_overmodulated;

    duty_set_t   pending_duties[$];
    logic [15:0] period_shadow;
    int          fail_count = 0;
    int          cycle_count = 0;

    space_vector_pwm_duty_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_phase_a_ref(i_phase_a_ref), .i_phase_b_ref(i_phase_b_ref),
        .i_phase_c_ref(i_phase_c_ref), .i_dc_bus(i_dc_bus),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data), .o_valid(o_valid), .o_duty_a(o_duty_a),
        .o_duty_b(o_duty_b), .o_duty_c(o_duty_c), .o_sector(o_sector),
        .o_overmodulated(o_overmodulated)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Timeout guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Compare value for one phase offset against the chosen denominator
    function automatic logic [15:0] phase_duty(input longint unsigned d,
                                               input longint unsigned den,
                                               input logic [15:0] period);
        longint unsigned t;
        t = (d << FRAC) / den;
        return 16'((longint'(period) * t + (64'd1 << (FRAC - 1))) >> FRAC);
    endfunction

    function automatic duty_set_t svpwm_predict(input logic [15:0] ra, rb, rc, bus,
                                                input logic [15:0] period);
        int a, b, c, mn, mx;
        longint unsigned dc, span, den;
        duty_set_t r;
        a = int'($signed(ra)); b = int'($signed(rb)); c = int'($signed(rc));
        dc = (bus == 0) ? 1 : bus;
        mn = a; if (b < mn) mn = b; if (c < mn) mn = c;
        mx = a; if (b > mx) mx = b; if (c > mx) mx = c;
        span = longint'(mx - mn);
        r.overmodulated = span > dc;
        den = r.overmodulated ? span : dc;
        if (b > c && a >= b)      r.sector = svpwm_pkg::SECTOR_1;
        else if (b > a && a >= c) r.sector = svpwm_pkg::SECTOR_2;
        else if (c > a && b >= c) r.sector = svpwm_pkg::SECTOR_3;
        else if (c > b && b >= a) r.sector = svpwm_pkg::SECTOR_4;
        else if (a > b && c >= a) r.sector = svpwm_pkg::SECTOR_5;
        else                      r.sector = svpwm_pkg::SECTOR_6;
        r.duty_a = phase_duty(longint'(a - mn), den, period);
        r.duty_b = phase_duty(longint'(b - mn), den, period);
        r.duty_c = phase_duty(longint'(c - mn), den, period);
        return r;
    endfunction

    // Result checker: strobe sampled at the rising edge
    always @(posedge i_clk) begin
        duty_set_t want;
        if (i_rst_n && o_valid) begin
            if (pending_duties.size() == 0) begin
                $error("unexpected result transaction");
                fail_count++;
            end else begin
                want = pending_duties.pop_front();
                if (o_duty_a !== want.duty_a) begin
                    $error("duty_a exp %0d got %0d", want.duty_a, o_duty_a);
                    fail_count++;
                end
                if (o_duty_b !== want.duty_b) begin
                    $error("duty_b exp %0d got %0d", want.duty_b, o_duty_b);
                    fail_count++;
                end
                if (o_duty_c !== want.duty_c) begin
                    $error("duty_c exp %0d got %0d", want.duty_c, o_duty_c);
                    fail_count++;
                end
                if (o_sector !== want.sector) begin
                    $error("sector exp %0d got %0d", want.sector, o_sector);
                    fail_count++;
                end
                if (o_overmodulated !== want.overmodulated) begin
                    $error("overmodulated exp %0b got %0b", want.overmodulated,
                           o_overmodulated);
                    fail_count++;
                end
            end
        end
    end

    // Issue one transaction, optionally with a typed-in expectation;
    // start is dropped only for an idle gap, so back-to-back items keep it high
    task automatic send_vector(input logic [15:0] a, b, c, bus, input int gap,
                               input logic known, input duty_set_t typed);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_phase_a_ref <= a; i_phase_b_ref <= b; i_phase_c_ref <= c;
        i_dc_bus <= bus;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_duties.push_back(known ? typed
                                       : svpwm_predict(a, b, c, bus, period_shadow));
    endtask

    // Wait for the pipeline to drain; write_period uses this before writing the period register
    task automatic drain_pipe();
        start <= 1'b0;
        while (pending_duties.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_period(input logic [15:0] p);
        drain_pipe();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= p;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        period_shadow = p;
    endtask

    function automatic logic [15:0] random_ref(input int mode, input logic [15:0] bus);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 200)) - 16'd100;
            default: return 16'(int'($urandom_range(0, bus)) - int'(bus / 2));
        endcase
    endfunction

    vec_row_t directed_rows[$];
    logic [15:0] periods[6] = '{16'd199, 16'd1, 16'd65535, 16'd0, 16'd1000, 16'd37};

    initial begin
        vec_row_t row;
        duty_set_t none;
        logic [15:0] bus;
        int mode;
        none = '0;

        // Directed table: extremes, every sector, special cases
        directed_rows = '{
            '{16'd0, 16'd0, 16'd0, 16'd100, 1'b1,
              '{16'd0, 16'd0, 16'd0, svpwm_pkg::SECTOR_6, 1'b0}},
            '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd0, 1'b1,
              '{16'd0, 16'd0, 16'd0, svpwm_pkg::SECTOR_6, 1'b0}},
            '{16'h7FFF, 16'h8000, 16'h8000, 16'd65535, 1'b1,
              '{16'd199, 16'd0, 16'd0, svpwm_pkg::SECTOR_6, 1'b0}},
            '{16'h8000, 16'h7FFF, 16'h7FFF, 16'd1, 1'b1,
              '{16'd0, 16'd199, 16'd199, svpwm_pkg::SECTOR_3, 1'b1}},
            '{16'd30, 16'd20, 16'd10, 16'd100, 1'b0, none},
            '{16'd20, 16'd30, 16'd10, 16'd100, 1'b0, none},
            '{16'd10, 16'd30, 16'd20, 16'd100, 1'b0, none},
            '{16'd10, 16'd20, 16'd30, 16'd100, 1'b0, none},
            '{16'd20, 16'd10, 16'd30, 16'd100, 1'b0, none},
            '{16'd30, 16'd10, 16'd20, 16'd100, 1'b0, none},
            '{16'd30, 16'd30, 16'd10, 16'd100, 1'b0, none},
            '{16'd10, 16'd30, 16'd30, 16'd100, 1'b0, none},
            '{16'd30, 16'd10, 16'd30, 16'd100, 1'b0, none},
            '{16'h8000, 16'd0, 16'h7FFF, 16'd65535, 1'b0, none},
            '{16'hFF00, 16'd500, 16'h0100, 16'd300, 1'b0, none},
            '{16'h5555, 16'hAAAA, 16'd0, 16'd40000, 1'b0, none}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        period_shadow = svpwm_pkg::PERIOD_RESET;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            send_vector(row.a, row.b, row.c, row.bus, $urandom_range(0, 17),
                        row.known, row.res);
        end
        write_period(16'd0);
        send_vector(16'd100, 16'hFF9C, 16'd0, 16'd300, 0, 1'b1,
                    '{16'd0, 16'd0, 16'd0, svpwm_pkg::SECTOR_6, 1'b0});

        // Random phases, period varied between phases
        for (int ph = 0; ph < 6; ph++) begin
            write_period(periods[ph] ^ (ph == 5 ? 16'($urandom) : 16'd0));
            for (int n = 0; n < 225; n++) begin
                bus = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 3))
                                                 : 16'($urandom);
                mode = $urandom_range(0, 2);
                // idle-free stretch in the middle of each phase
                send_vector(random_ref(mode, bus), random_ref(mode, bus),
                            random_ref(mode, bus), bus,
                            (n > 80 && n < 120) ? 0 : $urandom_range(0, 17),
                            1'b0, none);
                if (ph == 2 && n == 100) begin
                    start <= 1'b0;
                    while (pending_duties.size() != 0) @(posedge i_clk);
                end
            end
        end

        drain_pipe();
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
